// ===== sv/rccms_pkg.sv =====
// Shared types, codes and constants for the RC channel conditioner / mode selector.
// No dependencies; referenced by scoped name from rc_channel_conditioner_mode_select_unit.
package rccms_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int RAW_W        = 11;
    localparam int VAL_W        = 16;
    localparam int SCALE_W      = 24;
    localparam int GAP_W        = 32;
    localparam int DZ_W         = 10;
    localparam int MAP_W        = 15;
    localparam int SWEN_W       = 3;
    localparam int MODE_W       = 8;
    localparam int QUAL_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    // product of signed raw and unsigned scale, plus headroom for the rounding add
    localparam int PROD_W       = RAW_W + SCALE_W + 1;
    localparam int FRAC_W       = 16;
    localparam int SCALED_W     = PROD_W - FRAC_W - 1;
    localparam int NEG_W        = SCALED_W + 1;
    localparam int DIFF_W       = NEG_W + 1;

    localparam logic [GAP_W-1:0] GOOD_GAP_LIMIT = 32'd100000;
    localparam logic [GAP_W-1:0] LOSS_GAP_LIMIT = 32'd1500000;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    localparam logic signed [VAL_W-1:0] VAL_MAX       = 16'sd32767;
    localparam logic signed [VAL_W-1:0] VAL_MIN       = -16'sd32768;
    localparam logic signed [VAL_W-1:0] FAILSAFE_THR  = -16'sd8192;
    localparam logic signed [VAL_W-1:0] HALF_POS      = 16'sd4096;
    localparam logic signed [VAL_W-1:0] HALF_NEG      = -16'sd4096;
    localparam logic signed [VAL_W-1:0] STICK_HI      = 16'sd7373;
    localparam logic signed [VAL_W-1:0] STICK_LO      = -16'sd7373;
    localparam logic signed [VAL_W-1:0] THR_LOW       = -16'sd7783;

    localparam int ARMED_BIT  = 7;
    localparam int TEST_BIT   = 1;
    localparam int CUSTOM_BIT = 0;

    // channel_map slots
    localparam int SLOT_SAFETY  = 0;
    localparam int SLOT_MODE    = 1;
    localparam int SLOT_CUSTOM  = 2;
    localparam int SLOT_TEST    = 3;
    localparam int SLOT_DISABLE = 4;

    // switch_enables bits
    localparam int EN_CUSTOM  = 0;
    localparam int EN_TEST    = 1;
    localparam int EN_DISABLE = 2;

    // stick channels
    localparam int CH_THR   = 0;
    localparam int CH_ROLL  = 1;
    localparam int CH_PITCH = 2;
    localparam int CH_YAW   = 3;

    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_CALIBRATE = 2'd2,
        CMD_MODE      = 2'd3
    } cmd_t;

    typedef enum logic [QUAL_W-1:0] {
        QUAL_GOOD = 2'd0,
        QUAL_BAD  = 2'd1,
        QUAL_LOST = 2'd2
    } qual_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_FACTOR   = 3'd0,
        REG_DEAD_ZONE      = 3'd1,
        REG_INVERT_MASK    = 3'd2,
        REG_SAFETY_MODE    = 3'd3,
        REG_SWITCH_MODES   = 3'd4,
        REG_CHANNEL_MAP    = 3'd5,
        REG_SWITCH_ENABLES = 3'd6
    } cfg_reg_t;

    localparam logic [SCALE_W-1:0]      SCALE_RESET  = 24'd766958;
    localparam logic [DZ_W-1:0]         DZ_RESET     = 10'd30;
    localparam logic [NUM_CHANNELS-1:0] INVERT_RESET = NUM_CHANNELS'(2);

    // threshold flags kept per channel alongside its value
    typedef struct packed {
        logic pos;
        logic half_up;
        logic half_dn;
        logic stick_hi;
        logic stick_lo;
        logic thr_low;
    } ch_flags_t;

    function automatic ch_flags_t flags_of(logic signed [VAL_W-1:0] v);
        ch_flags_t f;
        f.pos      = (v > 16'sd0);
        f.half_up  = (v >= HALF_POS);
        f.half_dn  = (v <= HALF_NEG);
        f.stick_hi = (v >= STICK_HI);
        f.stick_lo = (v <= STICK_LO);
        f.thr_low  = (v <= THR_LOW);
        return f;
    endfunction

endpackage

// ===== sv/rc_channel_conditioner_mode_select_unit.sv =====
// Top level of the RC channel conditioner and desired-mode selector.
// A beat accepted into the input register moves on to the result register once the result side is not stalled.
// Throughput: one beat per cycle while result_stall stays low, set by the input register and result register pair
// around the single-pass conditioning and mode logic; the multiply sits before the input register.
// Reset: asynchronous, active low; channel values and trims zero, quality good,
// mode byte zero, configuration registers at their documented defaults.
// Depends on rccms_pkg.
module rc_channel_conditioner_mode_select_unit
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_write_en,
    input  logic [rccms_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rccms_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic [1:0]                              command,
    input  logic [rccms_pkg::CH_W-1:0]              channel_index,
    input  logic signed [rccms_pkg::RAW_W-1:0]      raw_value,
    input  logic [rccms_pkg::GAP_W-1:0]             gap_ticks,

    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [rccms_pkg::VAL_W-1:0]      channel_value,
    output logic [rccms_pkg::QUAL_W-1:0]            link_status,
    output logic [rccms_pkg::MODE_W-1:0]            desired_mode
);

    localparam int NCH = rccms_pkg::NUM_CHANNELS;
    localparam int CW  = rccms_pkg::CH_W;
    localparam int VW  = rccms_pkg::VAL_W;

    // ---------------- configuration registers ----------------
    logic [rccms_pkg::SCALE_W-1:0]  scale_factor_reg;
    logic [rccms_pkg::DZ_W-1:0]     dead_zone_reg;
    logic [NCH-1:0]                 invert_mask_reg;
    logic [rccms_pkg::MODE_W-1:0]   safety_mode_reg;
    logic [rccms_pkg::SCALE_W-1:0]  switch_modes_reg;
    logic [rccms_pkg::MAP_W-1:0]    channel_map_reg;
    logic [rccms_pkg::SWEN_W-1:0]   switch_enables_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg   <= rccms_pkg::SCALE_RESET;
            dead_zone_reg      <= rccms_pkg::DZ_RESET;
            invert_mask_reg    <= rccms_pkg::INVERT_RESET;
            safety_mode_reg    <= '0;
            switch_modes_reg   <= '0;
            channel_map_reg    <= '0;
            switch_enables_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rccms_pkg::REG_SCALE_FACTOR:
                    scale_factor_reg <= cfg_data[rccms_pkg::SCALE_W-1:0];
                rccms_pkg::REG_DEAD_ZONE:
                    dead_zone_reg <= cfg_data[rccms_pkg::DZ_W-1:0];
                rccms_pkg::REG_INVERT_MASK:
                    invert_mask_reg <= cfg_data[NCH-1:0];
                rccms_pkg::REG_SAFETY_MODE:
                    safety_mode_reg <= cfg_data[rccms_pkg::MODE_W-1:0];
                rccms_pkg::REG_SWITCH_MODES:
                    switch_modes_reg <= cfg_data[rccms_pkg::SCALE_W-1:0];
                rccms_pkg::REG_CHANNEL_MAP:
                    channel_map_reg <= cfg_data[rccms_pkg::MAP_W-1:0];
                rccms_pkg::REG_SWITCH_ENABLES:
                    switch_enables_reg <= cfg_data[rccms_pkg::SWEN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic result_valid_reg;
    logic result_valid_next;
    logic adv;
    logic accept;

    assign adv        = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !adv;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (adv)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // ---------------- input register: multiply and compares ----------------
    logic signed [rccms_pkg::PROD_W-1:0]    product;
    logic [rccms_pkg::PROD_W-1:0]           rounded;
    logic signed [rccms_pkg::RAW_W:0]       raw_ext;
    logic signed [rccms_pkg::RAW_W:0]       dz_ext;

    always_comb
    begin
        product = rccms_pkg::PROD_W'(raw_value)
                * $signed({1'b0, scale_factor_reg});
        rounded = product + rccms_pkg::ROUND_HALF;
        raw_ext = {raw_value[rccms_pkg::RAW_W-1], raw_value};
        dz_ext  = $signed({2'b00, dead_zone_reg});
    end

    rccms_pkg::cmd_t                          s1_cmd_reg;
    logic [CW-1:0]                            s1_ch_reg;
    logic signed [rccms_pkg::SCALED_W-1:0]    s1_scaled_reg;
    logic                                     s1_in_dz_reg;
    logic                                     s1_gap_good_reg;
    logic                                     s1_gap_bad_reg;
    logic                                     s1_gap_loss_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= rccms_pkg::cmd_t'(command);
            s1_ch_reg       <= channel_index;
            s1_scaled_reg   <= $signed(rounded[rccms_pkg::PROD_W-2:rccms_pkg::FRAC_W]);
            s1_in_dz_reg    <= (raw_ext < dz_ext) && (raw_ext > -dz_ext);
            s1_gap_good_reg <= (gap_ticks < rccms_pkg::GOOD_GAP_LIMIT);
            s1_gap_bad_reg  <= (gap_ticks < rccms_pkg::LOSS_GAP_LIMIT);
            s1_gap_loss_reg <= (gap_ticks > rccms_pkg::LOSS_GAP_LIMIT);
        end
    end

    // ---------------- channel state ----------------
    logic signed [VW-1:0] values_reg  [NCH];
    logic signed [VW-1:0] values_next [NCH];
    logic signed [VW-1:0] trims_reg   [NCH];
    logic signed [VW-1:0] trims_next  [NCH];
    logic [NCH-1:0]       pos_reg,      pos_next;
    logic [NCH-1:0]       half_up_reg,  half_up_next;
    logic [NCH-1:0]       half_dn_reg,  half_dn_next;
    logic [NCH-1:0]       stick_hi_reg, stick_hi_next;
    logic [NCH-1:0]       stick_lo_reg, stick_lo_next;
    logic [NCH-1:0]       thr_low_reg,  thr_low_next;
    logic [rccms_pkg::QUAL_W-1:0] quality_reg, quality_next;
    logic [rccms_pkg::MODE_W-1:0] mode_reg,    mode_next;

    // switch channel reads: a channel number past the last channel reads as zero
    function automatic logic flag_at(logic [NCH-1:0] vec, logic [CW-1:0] idx);
        logic r;
        r = 1'b0;
        if ({1'b0, idx} < (CW+1)'(NCH))
            r = vec[idx];
        return r;
    endfunction

    logic                                   ch_ok;
    logic signed [VW-1:0]                   cur_val;
    logic signed [VW-1:0]                   cur_trim;
    logic signed [rccms_pkg::NEG_W-1:0]     scaled_sgn;
    logic signed [rccms_pkg::DIFF_W-1:0]    diff;
    logic signed [VW-1:0]                   sample_val;
    logic signed [VW:0]                     cal_diff;
    logic signed [VW-1:0]                   cal_trim;
    logic [CW-1:0]                          map_safety;
    logic [CW-1:0]                          map_mode;
    logic [CW-1:0]                          map_custom;
    logic [CW-1:0]                          map_test;
    logic [CW-1:0]                          map_disable;
    logic                                   armed;
    logic                                   mode_skip;
    logic [rccms_pkg::MODE_W-1:0]           nm;
    rccms_pkg::ch_flags_t                   fl;

    always_comb
    begin
        ch_ok    = ({1'b0, s1_ch_reg} < (CW+1)'(NCH));
        cur_val  = ch_ok ? values_reg[s1_ch_reg] : '0;
        cur_trim = ch_ok ? trims_reg[s1_ch_reg]  : '0;

        // sample path: invert, remove trim, saturate; a raw value inside the dead zone gives zero
        scaled_sgn = rccms_pkg::NEG_W'(s1_scaled_reg);
        if (ch_ok && invert_mask_reg[s1_ch_reg])
            scaled_sgn = -scaled_sgn;
        diff = rccms_pkg::DIFF_W'(scaled_sgn) - rccms_pkg::DIFF_W'(cur_trim);
        if (diff > rccms_pkg::DIFF_W'(rccms_pkg::VAL_MAX))
            sample_val = rccms_pkg::VAL_MAX;
        else if (diff < rccms_pkg::DIFF_W'(rccms_pkg::VAL_MIN))
            sample_val = rccms_pkg::VAL_MIN;
        else
            sample_val = diff[VW-1:0];
        if (s1_in_dz_reg)
            sample_val = '0;

        // trim recalibration
        cal_diff = (VW+1)'(cur_val) - (VW+1)'(cur_trim);
        if (cal_diff > (VW+1)'(rccms_pkg::VAL_MAX))
            cal_trim = rccms_pkg::VAL_MAX;
        else if (cal_diff < (VW+1)'(rccms_pkg::VAL_MIN))
            cal_trim = rccms_pkg::VAL_MIN;
        else
            cal_trim = cal_diff[VW-1:0];

        // mode selection
        map_safety  = channel_map_reg[CW*rccms_pkg::SLOT_SAFETY  +: CW];
        map_mode    = channel_map_reg[CW*rccms_pkg::SLOT_MODE    +: CW];
        map_custom  = channel_map_reg[CW*rccms_pkg::SLOT_CUSTOM  +: CW];
        map_test    = channel_map_reg[CW*rccms_pkg::SLOT_TEST    +: CW];
        map_disable = channel_map_reg[CW*rccms_pkg::SLOT_DISABLE +: CW];

        mode_skip = switch_enables_reg[rccms_pkg::EN_DISABLE]
                 && !flag_at(half_up_reg, map_disable);

        // arm gesture: throttle low, yaw/pitch/roll high; disarm: throttle low, pitch high, yaw and roll low
        if (thr_low_reg[rccms_pkg::CH_THR] && stick_hi_reg[rccms_pkg::CH_YAW]
            && stick_hi_reg[rccms_pkg::CH_PITCH] && stick_hi_reg[rccms_pkg::CH_ROLL])
            armed = 1'b1;
        else if (thr_low_reg[rccms_pkg::CH_THR] && stick_lo_reg[rccms_pkg::CH_YAW]
            && stick_hi_reg[rccms_pkg::CH_PITCH] && stick_lo_reg[rccms_pkg::CH_ROLL])
            armed = 1'b0;
        else
            armed = mode_reg[rccms_pkg::ARMED_BIT];

        if (flag_at(pos_reg, map_safety))
        begin
            nm = safety_mode_reg;
            nm[rccms_pkg::ARMED_BIT] = armed;
        end
        else
        begin
            if (flag_at(half_up_reg, map_mode))
                nm = switch_modes_reg[23:16];
            else if (!flag_at(half_dn_reg, map_mode))
                nm = switch_modes_reg[15:8];
            else
                nm = switch_modes_reg[7:0];
            if (switch_enables_reg[rccms_pkg::EN_CUSTOM])
                nm[rccms_pkg::CUSTOM_BIT] = flag_at(pos_reg, map_custom);
            if (switch_enables_reg[rccms_pkg::EN_TEST])
                nm[rccms_pkg::TEST_BIT] = flag_at(pos_reg, map_test);
            nm[rccms_pkg::ARMED_BIT] = armed && mode_reg[rccms_pkg::ARMED_BIT];
        end

        // state update
        quality_next = quality_reg;
        mode_next    = mode_reg;
        for (int i = 0; i < NCH; i++)
        begin
            values_next[i] = values_reg[i];
            trims_next[i]  = trims_reg[i];
        end

        if (adv)
        begin
            unique case (s1_cmd_reg)
                rccms_pkg::CMD_SAMPLE:
                begin
                    if (s1_gap_good_reg)
                        quality_next = rccms_pkg::QUAL_GOOD;
                    else if (s1_gap_bad_reg)
                        quality_next = rccms_pkg::QUAL_BAD;
                    for (int i = 0; i < NCH; i++)
                        if (ch_ok && s1_ch_reg == CW'(i))
                            values_next[i] = sample_val;
                end
                rccms_pkg::CMD_TICK:
                begin
                    if (s1_gap_loss_reg)
                    begin
                        quality_next = rccms_pkg::QUAL_LOST;
                        for (int i = 0; i < NCH; i++)
                            values_next[i] = (i == rccms_pkg::CH_THR)
                                           ? rccms_pkg::FAILSAFE_THR : '0;
                    end
                end
                rccms_pkg::CMD_CALIBRATE:
                begin
                    for (int i = 0; i < NCH; i++)
                        if (ch_ok && s1_ch_reg == CW'(i))
                            trims_next[i] = cal_trim;
                end
                rccms_pkg::CMD_MODE:
                begin
                    if (!mode_skip)
                        mode_next = nm;
                end
                default:
                    ;
            endcase
        end

        for (int i = 0; i < NCH; i++)
        begin
            fl = rccms_pkg::flags_of(values_next[i]);
            pos_next[i]      = fl.pos;
            half_up_next[i]  = fl.half_up;
            half_dn_next[i]  = fl.half_dn;
            stick_hi_next[i] = fl.stick_hi;
            stick_lo_next[i] = fl.stick_lo;
            thr_low_next[i]  = fl.thr_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                values_reg[i] <= '0;
                trims_reg[i]  <= '0;
            end
            pos_reg      <= '0;
            half_up_reg  <= '0;
            half_dn_reg  <= '0;
            stick_hi_reg <= '0;
            stick_lo_reg <= '0;
            thr_low_reg  <= '0;
            quality_reg  <= rccms_pkg::QUAL_GOOD;
            mode_reg     <= '0;
        end
        else
        begin
            for (int i = 0; i < NCH; i++)
            begin
                values_reg[i] <= values_next[i];
                trims_reg[i]  <= trims_next[i];
            end
            pos_reg      <= pos_next;
            half_up_reg  <= half_up_next;
            half_dn_reg  <= half_dn_next;
            stick_hi_reg <= stick_hi_next;
            stick_lo_reg <= stick_lo_next;
            thr_low_reg  <= thr_low_next;
            quality_reg  <= quality_next;
            mode_reg     <= mode_next;
        end
    end

    // ---------------- result register ----------------
    logic signed [VW-1:0]           channel_value_reg;
    logic [rccms_pkg::QUAL_W-1:0]   link_status_reg;
    logic [rccms_pkg::MODE_W-1:0]   desired_mode_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            channel_value_reg <= ch_ok ? values_next[s1_ch_reg] : '0;
            link_status_reg   <= quality_next;
            desired_mode_reg  <= mode_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign channel_value = channel_value_reg;
    assign link_status   = link_status_reg;
    assign desired_mode  = desired_mode_reg;

endmodule

// ===== sim/tb_rc_channel_conditioner_mode_select_unit.sv =====
// Self-checking testbench for rc_channel_conditioner_mode_select_unit.
// Holds a scoreboard class that predicts each result beat; needs rccms_pkg and the top level.
`timescale 1ns / 100ps

module tb_rc_channel_conditioner_mode_select_unit;
    import rccms_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [QUAL_W-1:0]       quality;
        logic [MODE_W-1:0]       mode;
    } cond_result_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [CH_W-1:0]         ch;
        logic signed [RAW_W-1:0] raw;
        logic [GAP_W-1:0]        gap;
    } rc_beat_t;

    // Predicts conditioned channels, link quality and desired mode per input beat
    class channel_mode_tracker;
        logic [SCALE_W-1:0]      scale;
        logic [DZ_W-1:0]         dead_zone;
        logic [7:0]              invert;
        logic [MODE_W-1:0]       safety;
        logic [23:0]             sw_modes;
        logic [MAP_W-1:0]        chan_map;
        logic [SWEN_W-1:0]       sw_en;
        logic signed [VAL_W-1:0] chan_val [NUM_CHANNELS];
        logic signed [VAL_W-1:0] chan_trim [NUM_CHANNELS];
        logic [QUAL_W-1:0]       link_qual;
        logic [MODE_W-1:0]       mode_byte;
        cond_result_t            expected_outputs [$];
        int                      fails;
        int                      checked;

        function new();
            scale     = 24'd766958;
            dead_zone = 10'd30;
            invert    = 8'h02;
            safety    = '0;
            sw_modes  = '0;
            chan_map  = '0;
            sw_en     = '0;
            foreach (chan_val[i])
            begin
                chan_val[i]  = '0;
                chan_trim[i] = '0;
            end
            link_qual = QUAL_GOOD;
            mode_byte = '0;
            fails     = 0;
            checked   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_SCALE_FACTOR:   scale     = v[23:0];
                REG_DEAD_ZONE:      dead_zone = v[9:0];
                REG_INVERT_MASK:    invert    = v[7:0];
                REG_SAFETY_MODE:    safety    = v[7:0];
                REG_SWITCH_MODES:   sw_modes  = v[23:0];
                REG_CHANNEL_MAP:    chan_map  = v[14:0];
                REG_SWITCH_ENABLES: sw_en     = v[2:0];
                default: ;
            endcase
        endfunction

        function logic signed [VAL_W-1:0] clamp16(longint x);
            if (x > 32767)
                return 16'sd32767;
            if (x < -32768)
                return -16'sd32768;
            return VAL_W'(x);
        endfunction

        function int switch_of(int slot);
            return int'(chan_val[chan_map[3*slot +: 3]]);
        endfunction

        // stick gesture: low throttle with yaw, pitch and roll out arms; yaw and roll in with pitch out disarms
        function bit armed_after_gesture();
            int thr, roll, pitch, yaw;
            bit low_thr, pitch_hi;
            thr   = int'(chan_val[CH_THR]);
            roll  = int'(chan_val[CH_ROLL]);
            pitch = int'(chan_val[CH_PITCH]);
            yaw   = int'(chan_val[CH_YAW]);
            low_thr  = thr * 20 < -19 * 8192;
            pitch_hi = pitch * 10 > 73728;
            if (low_thr && yaw * 10 > 73728 && pitch_hi && roll * 10 > 73728)
                return 1'b1;
            if (low_thr && yaw * 10 < -73728 && pitch_hi && roll * 10 < -73728)
                return 1'b0;
            return mode_byte[ARMED_BIT];
        endfunction

        function void update_mode();
            logic [MODE_W-1:0] nm;
            bit armed;
            int m;
            if (sw_en[EN_DISABLE] && switch_of(SLOT_DISABLE) < 4096)
                return;
            armed = armed_after_gesture();
            if (switch_of(SLOT_SAFETY) > 0)
            begin
                nm = safety;
                nm[ARMED_BIT] = armed;
            end
            else
            begin
                m = switch_of(SLOT_MODE);
                if (m >= 4096)
                    nm = sw_modes[23:16];
                else if (m > -4096)
                    nm = sw_modes[15:8];
                else
                    nm = sw_modes[7:0];
                if (sw_en[EN_CUSTOM])
                    nm[CUSTOM_BIT] = switch_of(SLOT_CUSTOM) > 0;
                if (sw_en[EN_TEST])
                    nm[TEST_BIT] = switch_of(SLOT_TEST) > 0;
                // armed only survives here, it is never raised
                nm[ARMED_BIT] = armed & mode_byte[ARMED_BIT];
            end
            mode_byte = nm;
        endfunction

        function void note_beat(cmd_t cmd, logic [CH_W-1:0] ch, logic signed [RAW_W-1:0] raw,
                                logic [GAP_W-1:0] gap);
            cond_result_t e;
            longint s;
            int dz;
            case (cmd)
                CMD_SAMPLE:
                begin
                    if (gap < GOOD_GAP_LIMIT)
                        link_qual = QUAL_GOOD;
                    else if (gap < LOSS_GAP_LIMIT)
                        link_qual = QUAL_BAD;
                    dz = int'(dead_zone);
                    if (int'(raw) < dz && int'(raw) > -dz)
                        chan_val[ch] = '0;
                    else
                    begin
                        // round half up: floor((p + 32768) / 65536)
                        s = (longint'(raw) * longint'(scale) + 64'sd32768) >>> 16;
                        if (invert[ch])
                            s = -s;
                        chan_val[ch] = clamp16(s - longint'(chan_trim[ch]));
                    end
                end
                CMD_TICK:
                begin
                    if (gap > LOSS_GAP_LIMIT)
                    begin
                        foreach (chan_val[i])
                            chan_val[i] = '0;
                        chan_val[CH_THR] = -16'sd8192;
                        link_qual = QUAL_LOST;
                    end
                end
                CMD_CALIBRATE:
                    chan_trim[ch] = clamp16(longint'(chan_val[ch]) - longint'(chan_trim[ch]));
                default:
                    update_mode();
            endcase
            e.value   = chan_val[ch];
            e.quality = link_qual;
            e.mode    = mode_byte;
            expected_outputs.push_back(e);
        endfunction

        function void check_beat(logic signed [VAL_W-1:0] v, logic [QUAL_W-1:0] q,
                                 logic [MODE_W-1:0] m);
            cond_result_t e;
            if (expected_outputs.size() == 0)
            begin
                $display("%0t: unexpected result beat value=%0d quality=%0d mode=%02h",
                         $time, v, q, m);
                fails++;
                return;
            end
            e = expected_outputs.pop_front();
            checked++;
            if (v !== e.value)
            begin
                $display("%0t: channel_value expected %0d actual %0d", $time, e.value, v);
                fails++;
            end
            if (q !== e.quality)
            begin
                $display("%0t: link_status expected %0d actual %0d", $time, e.quality, q);
                fails++;
            end
            if (m !== e.mode)
            begin
                $display("%0t: desired_mode expected %02h actual %02h", $time, e.mode, m);
                fails++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    item_valid;
    logic                    item_stall;
    logic [1:0]              command;
    logic [CH_W-1:0]         channel_index;
    logic signed [RAW_W-1:0] raw_value;
    logic [GAP_W-1:0]        gap_ticks;
    logic                    result_valid;
    logic                    result_stall;
    logic signed [VAL_W-1:0] channel_value;
    logic [QUAL_W-1:0]       link_status;
    logic [MODE_W-1:0]       desired_mode;

    channel_mode_tracker sb;
    rc_beat_t            feed_q [$];
    bit                  calm_stretch;
    int                  beats_queued;
    int                  settings_done;
    int                  quiet_cycles;

    rc_channel_conditioner_mode_select_unit u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .channel_index  (channel_index),
        .raw_value      (raw_value),
        .gap_ticks      (gap_ticks),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .channel_value  (channel_value),
        .link_status    (link_status),
        .desired_mode   (desired_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input side: a beat stays put while stalled, otherwise the next one may idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                sb.note_beat(cmd_t'(command), channel_index, raw_value, gap_ticks);
                void'(feed_q.pop_front());
            end
            if (!(item_valid && item_stall))
            begin
                if (feed_q.size() != 0 && (calm_stretch || $urandom_range(99) >= 14))
                begin
                    item_valid    <= 1'b1;
                    command       <= feed_q[0].cmd;
                    channel_index <= feed_q[0].ch;
                    raw_value     <= feed_q[0].raw;
                    gap_ticks     <= feed_q[0].gap;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_beat(channel_value, link_status, desired_mode);
            result_stall <= !calm_stretch && ($urandom_range(99) < 14);
        end
    end

    // watchdog on cycles with work outstanding but no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (feed_q.size() == 0 && sb.expected_outputs.size() == 0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 2000)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic queue_beat(cmd_t cmd, int ch, int raw, logic [GAP_W-1:0] gap);
        rc_beat_t b;
        b.cmd = cmd;
        b.ch  = CH_W'(ch);
        b.raw = RAW_W'(raw);
        b.gap = gap;
        feed_q.push_back(b);
        beats_queued++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic program_regs(logic [23:0] scale, logic [9:0] dz, logic [7:0] inv,
                                logic [7:0] safe, logic [23:0] modes, logic [14:0] cmap,
                                logic [2:0] en);
        write_reg(REG_SCALE_FACTOR, scale);
        write_reg(REG_DEAD_ZONE, CFG_DATA_W'(dz));
        write_reg(REG_INVERT_MASK, CFG_DATA_W'(inv));
        write_reg(REG_SAFETY_MODE, CFG_DATA_W'(safe));
        write_reg(REG_SWITCH_MODES, modes);
        write_reg(REG_CHANNEL_MAP, CFG_DATA_W'(cmap));
        write_reg(REG_SWITCH_ENABLES, CFG_DATA_W'(en));
        settings_done++;
    endtask

    task automatic drain();
        while (feed_q.size() != 0 || sb.expected_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int pick_raw();
        int dz;
        dz = int'(sb.dead_zone);
        case ($urandom_range(4))
            0: return int'($urandom_range(2047)) - 1024;
            1: return ($urandom_range(1) ? 1 : -1) * (dz + int'($urandom_range(2)) - 1);
            2:
            begin
                case ($urandom_range(3))
                    0: return 1023;
                    1: return -1024;
                    2: return -1023;
                    default: return 0;
                endcase
            end
            default: return ($urandom_range(1) ? 1 : -1) * int'($urandom_range(600, 1023));
        endcase
    endfunction

    function automatic logic [GAP_W-1:0] pick_gap();
        case ($urandom_range(3))
            0: return GAP_W'($urandom_range(99999));
            1:
            begin
                case ($urandom_range(4))
                    0: return 32'd99999;
                    1: return 32'd100000;
                    2: return 32'd1499999;
                    3: return 32'd1500000;
                    default: return 32'd1500001;
                endcase
            end
            2: return GAP_W'($urandom_range(1600000, 100000));
            default: return $urandom;
        endcase
    endfunction

    // strong stick deflection of the wanted sign, allowing for the invert mask
    function automatic int stick_raw(int ch, bit positive);
        int v;
        v = int'($urandom_range(650, 1023));
        if (!positive)
            v = -v;
        if (sb.invert[ch])
            v = -v;
        return v;
    endfunction

    // sticks into an arm or disarm pose, a few switch moves, then a mode update;
    // now and then one stick gets a random value instead, which may break the gesture
    task automatic queue_gesture(output int n);
        bit arm_pose;
        int broken;
        n = 0;
        arm_pose = $urandom_range(1);
        broken = ($urandom_range(9) == 0) ? int'($urandom_range(3)) : -1;
        for (int c = CH_THR; c <= CH_YAW; c++)
        begin
            if (c == broken)
                queue_beat(CMD_SAMPLE, c, pick_raw(), GAP_W'($urandom_range(99999)));
            else if (c == CH_THR)
                queue_beat(CMD_SAMPLE, c, stick_raw(c, 1'b0), GAP_W'($urandom_range(99999)));
            else if (c == CH_PITCH)
                queue_beat(CMD_SAMPLE, c, stick_raw(c, 1'b1), GAP_W'($urandom_range(99999)));
            else
                queue_beat(CMD_SAMPLE, c, stick_raw(c, arm_pose), GAP_W'($urandom_range(99999)));
            n++;
        end
        for (int c = 4; c < NUM_CHANNELS; c++)
        begin
            if ($urandom_range(1))
            begin
                case ($urandom_range(3))
                    0: queue_beat(CMD_SAMPLE, c, 1000, pick_gap());
                    1: queue_beat(CMD_SAMPLE, c, -1000, pick_gap());
                    2: queue_beat(CMD_SAMPLE, c, 0, pick_gap());
                    default: queue_beat(CMD_SAMPLE, c, pick_raw(), pick_gap());
                endcase
                n++;
            end
        end
        queue_beat(CMD_MODE, $urandom_range(7), pick_raw(), $urandom);
        n++;
    endtask

    task automatic queue_random(int count);
        int n;
        int k;
        n = 0;
        while (n < count)
        begin
            k = $urandom_range(99);
            if (k < 35)
            begin
                queue_gesture(k);
                n += k;
            end
            else
            begin
                if (k < 60)
                    queue_beat(CMD_SAMPLE, $urandom_range(7), pick_raw(), pick_gap());
                else if (k < 70)
                    queue_beat(CMD_TICK, $urandom_range(7), pick_raw(), pick_gap());
                else if (k < 78)
                    queue_beat(CMD_CALIBRATE, $urandom_range(7), pick_raw(), $urandom);
                else
                    queue_beat(CMD_MODE, $urandom_range(7), pick_raw(), $urandom);
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        item_valid    = 1'b0;
        command       = '0;
        channel_index = '0;
        raw_value     = '0;
        gap_ticks     = '0;
        result_stall  = 1'b0;
        calm_stretch  = 1'b0;
        beats_queued  = 0;
        settings_done = 0;
        quiet_cycles  = 0;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: dead zone edges, quality limits, failsafe, trim round trip
        queue_beat(CMD_SAMPLE, 0, 0, 32'd0);
        queue_beat(CMD_SAMPLE, 0, 29, 32'd99999);
        queue_beat(CMD_SAMPLE, 0, 30, 32'd100000);
        queue_beat(CMD_SAMPLE, 1, -30, 32'd1499999);
        queue_beat(CMD_SAMPLE, 2, -29, 32'd1500000);
        queue_beat(CMD_SAMPLE, 3, 1023, 32'hFFFF_FFFF);
        queue_beat(CMD_SAMPLE, 4, -1024, 32'd0);
        queue_beat(CMD_TICK, 5, 0, 32'd1500000);
        queue_beat(CMD_TICK, 6, 0, 32'd1500001);
        queue_beat(CMD_SAMPLE, 7, 1023, 32'd0);
        queue_beat(CMD_CALIBRATE, 7, 0, 32'd0);
        queue_beat(CMD_SAMPLE, 7, 1023, 32'd0);
        queue_beat(CMD_CALIBRATE, 7, 0, 32'd0);
        queue_beat(CMD_MODE, 7, 0, 32'd0);
        drain();

        // hand-picked switch map, no idling: arm, switch modes, disarm, updates blocked
        calm_stretch = 1'b1;
        program_regs(24'd766958, 10'd30, 8'h00, 8'hA5, 24'h3C5A96,
                     15'((5 << 12) | (7 << 9) | (6 << 6) | (5 << 3) | 4), 3'b111);
        queue_beat(CMD_SAMPLE, 5, 1000, 32'd0);
        queue_beat(CMD_SAMPLE, 0, -1000, 32'd0);
        queue_beat(CMD_SAMPLE, 1, 1000, 32'd0);
        queue_beat(CMD_SAMPLE, 2, 1000, 32'd0);
        queue_beat(CMD_SAMPLE, 3, 1000, 32'd0);
        queue_beat(CMD_SAMPLE, 4, 1000, 32'd0);
        queue_beat(CMD_MODE, 0, 0, 32'd0);
        queue_beat(CMD_SAMPLE, 4, -1000, 32'd0);
        queue_beat(CMD_SAMPLE, 6, 1000, 32'd0);
        queue_beat(CMD_MODE, 6, 0, 32'd0);
        queue_beat(CMD_SAMPLE, 3, -1000, 32'd0);
        queue_beat(CMD_SAMPLE, 1, -1000, 32'd0);
        queue_beat(CMD_MODE, 1, 0, 32'd0);
        queue_beat(CMD_SAMPLE, 5, 0, 32'd0);
        queue_beat(CMD_MODE, 5, 0, 32'd0);
        queue_random(190);
        drain();
        calm_stretch = 1'b0;

        // all registers at their top values, then all at zero
        program_regs(24'hFFFFFF, 10'h3FF, 8'hFF, 8'hFF, 24'hFFFFFF, 15'h7FFF, 3'b111);
        queue_random(190);
        drain();
        program_regs(24'h000000, 10'h000, 8'h00, 8'h00, 24'h000000, 15'h0000, 3'b000);
        queue_random(190);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            program_regs(($urandom_range(7) == 0) ? 24'($urandom)
                                                  : 24'($urandom_range(4000000, 500000)),
                         10'($urandom_range(100)), 8'($urandom), 8'($urandom),
                         24'($urandom), 15'($urandom), 3'($urandom));
            queue_random(190);
            drain();
        end

        $display("Ran %0d input beats across %0d register settings; %0d results compared.",
                 beats_queued, settings_done + 1, sb.checked);
        if (sb.expected_outputs.size() != 0)
            sb.fails++;
        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
